### sv/separated_integer_list_parser_top_defines.svh
// Assertion macros shared by the parser's modules.
// Each use expects clk and rst_n to be visible in the module that uses it.
`ifndef SEPARATED_INTEGER_LIST_PARSER_TOP_DEFINES_SVH
`define SEPARATED_INTEGER_LIST_PARSER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge out of reset.
`define SLP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("slp: assertion failed");

// A condition in this cycle that requires a consequence in the same cycle.
`define SLP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slp: implication failed");

// A condition in this cycle that requires a consequence in the next cycle.
`define SLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slp: next-cycle check failed");

`else

`define SLP_ASSERT(lbl, prop)
`define SLP_ASSERT_IMPL(lbl, ante, cons)
`define SLP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### sv/slp_pkg.sv
package slp_pkg;

  // Width of the running byte position; it saturates at its all-ones value.
  localparam int POS_BITS = 16;
  localparam int ERR_POS_BITS = 16;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] SEP_RESET = 8'h2C;

  typedef enum logic [2:0] {
    KIND_VALUE  = 3'd0,
    KIND_DONE   = 3'd1,
    KIND_INTEXP = 3'd2,
    KIND_RANGE  = 3'd3,
    KIND_SEPEXP = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    kind_t                    result_kind;
    logic signed [31:0]       parsed_value;
    logic [ERR_POS_BITS-1:0]  error_position;
    logic                     last_of_string;
  } out_word_t;

  // One input word after classification by the front end.
  typedef struct packed {
    logic [3:0] digit_val;
    logic       is_marker;
    logic       is_zero;
    logic       is_digit;
    logic       is_space;
    logic       is_blank;
    logic       is_sign;
    logic       is_minus;
    logic       is_sep;
  } cls_t;

  function automatic logic is_digit_char(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

### sv/slp_front.sv
module slp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  slp_pkg::in_word_t in_data,
  output logic             in_stall,
  input  logic             cfg_valid,
  input  logic [7:0]       cfg_data,
  output logic             cfg_ready,
  input  logic             q_full,
  output logic             q_push,
  output slp_pkg::cls_t    q_item
);
  import slp_pkg::*;

  logic [7:0] sep_r;
  logic [7:0] sep_nxt;
  logic [7:0] c;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign c         = in_data.char_byte;

  // Digits and signs would make the list ambiguous, so such writes are dropped.
  always_comb begin
    sep_nxt = sep_r;
    if (cfg_valid && cfg_ready && !is_digit_char(cfg_data) &&
        cfg_data != CH_PLUS && cfg_data != CH_MINUS) begin
      sep_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET;
    end else begin
      sep_r <= sep_nxt;
    end
  end

  always_comb begin
    q_item.digit_val = c[3:0];
    q_item.is_marker = in_data.end_of_string;
    q_item.is_zero   = !in_data.end_of_string && (c == CH_NUL);
    q_item.is_digit  = is_digit_char(c);
    q_item.is_space  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    q_item.is_blank  = (c == CH_SPACE) || (c == CH_TAB);
    q_item.is_sign   = (c == CH_PLUS) || (c == CH_MINUS);
    q_item.is_minus  = (c == CH_MINUS);
    q_item.is_sep    = (c == sep_r);
  end

endmodule

### sv/slp_queue.sv
`include "separated_integer_list_parser_top_defines.svh"

module slp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  slp_pkg::cls_t push_item,
  output logic          full,
  output logic          head_valid,
  output slp_pkg::cls_t head_item,
  input  logic          pop
);
  import slp_pkg::*;

  cls_t       ent_r   [2];
  cls_t       ent_nxt [2];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [1:0] cnt_after;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = ent_r[0];

  always_comb begin
    ent_nxt   = ent_r;
    cnt_after = cnt_r;
    if (pop) begin
      ent_nxt[0] = ent_r[1];
      cnt_after  = cnt_r - 2'd1;
    end
    cnt_nxt = cnt_after;
    if (push) begin
      ent_nxt[cnt_after[0]] = push_item;
      cnt_nxt               = cnt_after + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  `SLP_ASSERT(a_q_cnt_range, cnt_r <= 2'd2)
  `SLP_ASSERT_IMPL(a_q_no_push_full, push, cnt_r != 2'd2)
  `SLP_ASSERT_NEXT(a_q_fill_one, push && !pop && cnt_r == 2'd0, cnt_r == 2'd1)

endmodule

### sv/slp_back.sv
`include "separated_integer_list_parser_top_defines.svh"

module slp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  slp_pkg::cls_t      q_item,
  output logic               q_pop,
  output logic               out_valid,
  output slp_pkg::out_word_t out_data,
  input  logic               out_stall
);
  import slp_pkg::*;

  typedef enum logic [2:0] {
    PH_START,
    PH_LEADWS,
    PH_SIGN,
    PH_DIGITS,
    PH_TRAIL,
    PH_DRAIN
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [31:0]         mag_r, mag_nxt;
  logic                big_r, big_nxt;
  logic                minus_r, minus_nxt;
  logic [POS_BITS-1:0] bpos_r, bpos_nxt;
  logic [POS_BITS-1:0] spos_r, spos_nxt;
  out_word_t           oq_r [2];
  out_word_t           oq_nxt [2];
  logic [1:0]          ocnt_r, ocnt_nxt;

  logic [POS_BITS-1:0] pos;
  logic                ends;
  logic [1:0]          nres;
  out_word_t           res_a, res_b;
  logic                out_pop;
  logic [1:0]          ocnt_after;
  logic [2:0]          ocnt_sum;

  function automatic logic [ERR_POS_BITS-1:0] err_pos(input logic [POS_BITS-1:0] p);
    if (32'(p) > 32'h0000_FFFF) begin
      return '1;
    end
    return ERR_POS_BITS'(p);
  endfunction

  function automatic out_word_t mk_res(input kind_t k, input logic [31:0] v,
                                       input logic [ERR_POS_BITS-1:0] ep,
                                       input logic lst);
    out_word_t r;
    r.result_kind    = k;
    r.parsed_value   = v;
    r.error_position = ep;
    r.last_of_string = lst;
    return r;
  endfunction

  assign out_valid  = (ocnt_r != 2'd0);
  assign out_data   = oq_r[0];
  assign out_pop    = out_valid && !out_stall;
  assign ocnt_after = ocnt_r - {1'b0, out_pop};
  assign ocnt_sum   = {1'b0, ocnt_after} + {1'b0, nres};
  assign q_pop      = q_valid && (ocnt_sum <= 3'd2);

  assign pos  = (bpos_r == '1) ? bpos_r : bpos_r + 1'b1;
  assign ends = q_item.is_marker || q_item.is_zero;

  // Parse step for the word at the head of the queue.
  always_comb begin
    logic [35:0]         m10;
    logic                big2;
    logic [POS_BITS-1:0] sp;
    out_word_t           an_res;
    logic                an_emit;
    logic                do_after;
    logic                big_use;

    m10       = 36'(mag_r) * 36'd10 + 36'(q_item.digit_val);
    big2      = 1'b0;
    sp        = spos_r;
    an_res    = '0;
    an_emit   = 1'b0;
    do_after  = 1'b0;
    big_use   = big_r;
    phase_nxt = phase_r;
    mag_nxt   = mag_r;
    big_nxt   = big_r;
    minus_nxt = minus_r;
    bpos_nxt  = bpos_r;
    spos_nxt  = spos_r;
    res_a     = '0;
    res_b     = '0;
    nres      = 2'd0;

    if (q_valid) begin
      if (!q_item.is_marker) begin
        bpos_nxt = pos;
      end
      case (phase_r)
        PH_START, PH_LEADWS: begin
          if (phase_r == PH_START) begin
            sp       = pos;
            spos_nxt = pos;
          end
          if (phase_r == PH_START && ends) begin
            res_a     = mk_res(KIND_DONE, '0, '0, 1'b1);
            nres      = 2'd1;
            phase_nxt = PH_DRAIN;
          end else if (ends) begin
            res_a     = mk_res(KIND_INTEXP, '0, err_pos(sp), 1'b1);
            nres      = 2'd1;
            phase_nxt = PH_DRAIN;
          end else if (q_item.is_space) begin
            phase_nxt = PH_LEADWS;
          end else if (q_item.is_sign) begin
            minus_nxt = q_item.is_minus;
            phase_nxt = PH_SIGN;
          end else if (q_item.is_digit) begin
            mag_nxt   = 32'(q_item.digit_val);
            big_nxt   = 1'b0;
            phase_nxt = PH_DIGITS;
          end else begin
            res_a     = mk_res(KIND_INTEXP, '0, err_pos(sp), 1'b1);
            nres      = 2'd1;
            phase_nxt = PH_DRAIN;
          end
        end
        PH_SIGN: begin
          if (!ends && q_item.is_digit) begin
            mag_nxt   = 32'(q_item.digit_val);
            big_nxt   = 1'b0;
            phase_nxt = PH_DIGITS;
          end else begin
            res_a     = mk_res(KIND_INTEXP, '0, err_pos(spos_r), 1'b1);
            nres      = 2'd1;
            phase_nxt = PH_DRAIN;
          end
        end
        PH_DIGITS: begin
          if (!ends && q_item.is_digit) begin
            if (!big_r) begin
              if (m10 > 36'h0_8000_0000) begin
                big_nxt = 1'b1;
              end else begin
                mag_nxt = m10[31:0];
              end
            end
          end else begin
            // A positive magnitude of 2^31 fits only with a minus sign.
            big2     = big_r || (!minus_r && mag_r[31]);
            big_nxt  = big2;
            big_use  = big2;
            do_after = 1'b1;
            if (!big2) begin
              res_a = mk_res(KIND_VALUE, minus_r ? (32'd0 - mag_r) : mag_r, '0, 1'b0);
              nres  = 2'd1;
            end
          end
        end
        PH_TRAIL: begin
          do_after = 1'b1;
        end
        default: begin
          phase_nxt = PH_DRAIN;
        end
      endcase

      // After a number: blanks, separator, end, range or separator error.
      if (do_after) begin
        if (!ends && q_item.is_blank) begin
          phase_nxt = PH_TRAIL;
        end else if (big_use) begin
          an_res    = mk_res(KIND_RANGE, '0, err_pos(pos), 1'b1);
          an_emit   = 1'b1;
          phase_nxt = PH_DRAIN;
        end else if (ends) begin
          an_res    = mk_res(KIND_DONE, '0, '0, 1'b1);
          an_emit   = 1'b1;
          phase_nxt = PH_DRAIN;
        end else if (q_item.is_sep) begin
          phase_nxt = PH_START;
          mag_nxt   = '0;
          minus_nxt = 1'b0;
        end else begin
          an_res    = mk_res(KIND_SEPEXP, '0, err_pos(pos), 1'b1);
          an_emit   = 1'b1;
          phase_nxt = PH_DRAIN;
        end
        if (an_emit) begin
          if (nres == 2'd0) begin
            res_a = an_res;
            nres  = 2'd1;
          end else begin
            res_b = an_res;
            nres  = 2'd2;
          end
        end
      end

      if (q_item.is_zero) begin
        phase_nxt = PH_DRAIN;
      end
      if (q_item.is_marker) begin
        phase_nxt = PH_START;
        mag_nxt   = '0;
        big_nxt   = 1'b0;
        minus_nxt = 1'b0;
        bpos_nxt  = '0;
        spos_nxt  = '0;
      end
    end
  end

  // Result queue: shift out on a take, then append this word's results.
  always_comb begin
    oq_nxt   = oq_r;
    ocnt_nxt = ocnt_after;
    if (out_pop) begin
      oq_nxt[0] = oq_r[1];
    end
    if (q_pop) begin
      if (nres == 2'd2) begin
        oq_nxt[0] = res_a;
        oq_nxt[1] = res_b;
      end else if (nres == 2'd1) begin
        oq_nxt[ocnt_after[0]] = res_a;
      end
      ocnt_nxt = ocnt_sum[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      mag_r   <= '0;
      big_r   <= 1'b0;
      minus_r <= 1'b0;
      bpos_r  <= '0;
      spos_r  <= '0;
      ocnt_r  <= 2'd0;
      oq_r[0] <= '0;
      oq_r[1] <= '0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        mag_r   <= mag_nxt;
        big_r   <= big_nxt;
        minus_r <= minus_nxt;
        bpos_r  <= bpos_nxt;
        spos_r  <= spos_nxt;
      end
      ocnt_r <= ocnt_nxt;
      oq_r   <= oq_nxt;
    end
  end

  `SLP_ASSERT(a_b_ocnt_range, ocnt_r <= 2'd2)
  `SLP_ASSERT_IMPL(a_b_drain_silent, q_pop && phase_r == PH_DRAIN, nres == 2'd0)
  `SLP_ASSERT_IMPL(a_b_pair_ends, nres == 2'd2, res_a.result_kind == KIND_VALUE && res_b.last_of_string)

endmodule

### sv/separated_integer_list_parser_top.sv
// Channel  Direction  Handshake          Word
// in_      input      in_valid/in_stall  slp_pkg::in_word_t (char_byte, end_of_string)
// out_     output     out_valid/out_stall slp_pkg::out_word_t (kind, value, position, last)
// cfg_     input      cfg_valid/cfg_ready 8-bit separator byte
//
// One input word is taken per cycle while in_stall is low; each word is parsed from
// the head of the two-entry classified-word queue, and its results leave through a
// two-entry result queue, one result word per cycle while out_stall is low.
// A word that closes a number and also ends the string gives two results; it is
// parsed only once both fit in the result queue, so such a word can hold up the parse.
// Reset is synchronous and active low; it restores the comma separator and the
// fresh per-string state. in_stall rises only when the word queue is full.
module separated_integer_list_parser_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  slp_pkg::in_word_t  in_data,
  output logic               in_stall,
  output logic               out_valid,
  output slp_pkg::out_word_t out_data,
  input  logic               out_stall,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_data,
  output logic               cfg_ready
);
  import slp_pkg::*;

  // Front end: separator register and byte classification.
  logic q_full;
  logic q_push;
  cls_t q_in;

  // Queue head seen by the parser.
  logic q_valid;
  logic q_pop;
  cls_t q_head;

  slp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  // The queue lets the front keep taking words while the parser waits on
  // the output side.
  slp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in),
    .full       (q_full),
    .head_valid (q_valid),
    .head_item  (q_head),
    .pop        (q_pop)
  );

  // Back end: the parse state machine and the result queue.
  slp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
